### rtl/core/assert_macros.svh
// Assertion macros for the checker of the dice-sum core.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define DSWMP_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dswmp assertion failed");

// Next-cycle implication.
`define DSWMP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dswmp assertion failed");

`endif

### rtl/core/dswmp_pkg.sv
// Shared constants, types and the microcode program of the dice-sum core.
// No dependencies; the files that use it refer to it by scoped names.
package dswmp_pkg;

    localparam int ORDER     = 6;                  // die faces / matrix order, 2..8
    localparam int IDX_W     = 3;                  // row/column index, covers order 8
    localparam int SLOT_W    = 2;                  // slot index width, four matrix slots in the RAM
    localparam int ADDR_W    = SLOT_W + 2 * IDX_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;
    localparam int DATA_W    = 30;
    localparam int EXP_W     = 63;
    localparam int MUL_LAT   = 4;                  // modular multiplier stages
    localparam int TAG_DEPTH = MUL_LAT + 1;        // plus the RAM read stage

    localparam logic [DATA_W-1:0] MODP = 30'd1000000007;
    localparam logic [63:0] BARRETT_M64 = (64'd1 << 60) / 64'd1000000007;
    localparam logic [30:0] BARRETT_M = BARRETT_M64[30:0];

    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ORDER - 1);

    localparam logic [SLOT_W-1:0] SLOT_ACC0  = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_BASE0 = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_FREE0 = 2'd2;

    // Microcode steps
    localparam int PC_W = 3;
    localparam logic [PC_W-1:0] PC_IDLE = 3'd0;
    localparam logic [PC_W-1:0] PC_TEST = 3'd1;
    localparam logic [PC_W-1:0] PC_BIT  = 3'd2;
    localparam logic [PC_W-1:0] PC_MUL  = 3'd3;
    localparam logic [PC_W-1:0] PC_SQR  = 3'd4;
    localparam logic [PC_W-1:0] PC_LOOP = 3'd5;
    localparam logic [PC_W-1:0] PC_PEEK = 3'd6;
    localparam logic [PC_W-1:0] PC_EMIT = 3'd7;

    // Jump conditions: jump to target when true, else fall through to pc+1
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_N_ZERO,
        COND_N_EVEN,
        COND_MAT_BUSY,
        COND_OUT_BUSY
    } cond_t;

    typedef struct packed {
        logic            load;      // input ready, capture exponent
        logic            mat_req;   // run a matrix product
        logic            mat_sq;    // product kind: base*base, else acc*base
        logic            emit;      // load output register
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    typedef enum logic [1:0] {
        ENG_IDLE,
        ENG_RUN,
        ENG_DRAIN,
        ENG_DONE
    } eng_state_t;

    typedef struct packed {
        logic init;     // reset matrix pointers: acc = identity, base = companion
        logic req;
        logic sq;
    } eng_ctrl_t;

    typedef struct packed {
        logic              done;       // one cycle, product written back
        logic [DATA_W-1:0] peek_data;  // acc[0][0] while the engine is idle
    } eng_stat_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t uc;
        uc = '{load: 1'b0, mat_req: 1'b0, mat_sq: 1'b0, emit: 1'b0,
               cond: COND_NEVER, target: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                uc.load   = 1'b1;
                uc.cond   = COND_NO_INPUT;
                uc.target = PC_IDLE;
            end
            PC_TEST: begin
                uc.cond   = COND_N_ZERO;
                uc.target = PC_PEEK;
            end
            PC_BIT: begin
                uc.cond   = COND_N_EVEN;
                uc.target = PC_SQR;
            end
            PC_MUL: begin
                uc.mat_req = 1'b1;
                uc.cond    = COND_MAT_BUSY;
                uc.target  = PC_MUL;
            end
            PC_SQR: begin
                uc.mat_req = 1'b1;
                uc.mat_sq  = 1'b1;
                uc.cond    = COND_MAT_BUSY;
                uc.target  = PC_SQR;
            end
            PC_LOOP: begin
                uc.cond   = COND_ALWAYS;
                uc.target = PC_TEST;
            end
            PC_PEEK: begin
                uc.cond   = COND_NEVER;
                uc.target = PC_PEEK;
            end
            PC_EMIT: begin
                // falls through by wrap-around to PC_IDLE
                uc.emit   = 1'b1;
                uc.cond   = COND_OUT_BUSY;
                uc.target = PC_EMIT;
            end
            default: begin
                uc.cond   = COND_ALWAYS;
                uc.target = PC_IDLE;
            end
        endcase
        return uc;
    endfunction

    // Entry (r,c) of the identity matrix
    function automatic logic ident_one(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        return r == c;
    endfunction

    // Entry (r,c) of the companion matrix: top row ones, subdiagonal ones
    function automatic logic comp_one(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
        return (r == '0) || ({1'b0, r} == ({1'b0, c} + 4'd1));
    endfunction

endpackage

### rtl/core/dswmp_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module dswmp_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/core/dswmp_modmul.sv
// Pipelined modular multiplier, a*b mod p, Barrett reduction, four stages.
// Depends on dswmp_pkg.
module dswmp_modmul (
    input  logic                         clk,
    input  logic [dswmp_pkg::DATA_W-1:0] a,
    input  logic [dswmp_pkg::DATA_W-1:0] b,
    output logic [dswmp_pkg::DATA_W-1:0] red
);

    localparam logic [31:0] ONE_P = {2'b00, dswmp_pkg::MODP};
    localparam logic [31:0] TWO_P = {1'b0, dswmp_pkg::MODP, 1'b0};

    logic [59:0] prod_full;
    logic [59:0] prod1_reg;
    logic [61:0] t1_full;
    logic [61:0] t1_reg;
    logic [31:0] prod2_reg;
    logic [60:0] qp_full;
    logic [31:0] qp_reg;
    logic [31:0] prod3_reg;
    logic [31:0] r_diff;
    logic [31:0] r_fix;
    logic [dswmp_pkg::DATA_W-1:0] red_reg;

    assign prod_full = a * b;
    assign t1_full   = prod1_reg[59:29] * dswmp_pkg::BARRETT_M;
    assign qp_full   = t1_reg[61:31] * dswmp_pkg::MODP;

    // remainder estimate is below 3p and fits 32 bits
    assign r_diff = prod3_reg - qp_reg;

    always_comb
    begin
        if (r_diff >= TWO_P)
        begin
            r_fix = r_diff - TWO_P;
        end
        else if (r_diff >= ONE_P)
        begin
            r_fix = r_diff - ONE_P;
        end
        else
        begin
            r_fix = r_diff;
        end
    end

    always_ff @(posedge clk)
    begin
        prod1_reg <= prod_full;
        t1_reg    <= t1_full;
        prod2_reg <= prod1_reg[31:0];
        qp_reg    <= qp_full[31:0];
        prod3_reg <= prod2_reg;
        red_reg   <= r_fix[dswmp_pkg::DATA_W-1:0];
    end

    assign red = red_reg;

endmodule

### rtl/core/dswmp_engine.sv
// Matrix product engine: index counters, slot pointers, matrix RAM,
// modular multiplier and accumulator. Depends on dswmp_pkg, dswmp_ram, dswmp_modmul.
module dswmp_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dswmp_pkg::eng_ctrl_t ctrl,
    output dswmp_pkg::eng_stat_t stat
);

    localparam int IW = dswmp_pkg::IDX_W;
    localparam int SW = dswmp_pkg::SLOT_W;
    localparam int AW = dswmp_pkg::ADDR_W;
    localparam int DW = dswmp_pkg::DATA_W;

    typedef struct packed {
        logic          valid;
        logic          first;
        logic          last;
        logic [AW-1:0] waddr;
    } tag_t;

    dswmp_pkg::eng_state_t state_reg, state_next;
    logic [IW-1:0] i_reg, i_next;
    logic [IW-1:0] j_reg, j_next;
    logic [IW-1:0] k_reg, k_next;
    logic          sq_reg, sq_next;
    logic [SW-1:0] a_slot_reg, a_slot_next;
    logic [SW-1:0] b_slot_reg, b_slot_next;
    logic [SW-1:0] f_slot_reg, f_slot_next;
    logic          a_virt_reg, a_virt_next;
    logic          b_virt_reg, b_virt_next;

    logic          issue;
    logic [SW-1:0] x_slot;
    logic [AW-1:0] raddr_a, raddr_b;
    logic [DW-1:0] rdata_a, rdata_b;
    logic          x_cst, x_cbit, y_cst, y_cbit;
    logic          x_cst_reg, x_cbit_reg, y_cst_reg, y_cbit_reg;
    logic [DW-1:0] x_data, y_data;
    logic [DW-1:0] red;

    tag_t          tag_reg [dswmp_pkg::TAG_DEPTH];
    tag_t          tag_out;
    logic          pipe_busy;

    logic [DW-1:0] acc_reg;
    logic [DW:0]   sum_wide;
    logic [DW:0]   sum_mod;
    logic [DW-1:0] acc_sum;
    logic          we;

    assign issue = (state_reg == dswmp_pkg::ENG_RUN);

    // sequencing and pointer update
    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        sq_next     = sq_reg;
        a_slot_next = a_slot_reg;
        b_slot_next = b_slot_reg;
        f_slot_next = f_slot_reg;
        a_virt_next = a_virt_reg;
        b_virt_next = b_virt_reg;
        case (state_reg)
            dswmp_pkg::ENG_IDLE:
            begin
                if (ctrl.req)
                begin
                    state_next = dswmp_pkg::ENG_RUN;
                    sq_next    = ctrl.sq;
                    i_next     = '0;
                    j_next     = '0;
                    k_next     = '0;
                end
            end
            dswmp_pkg::ENG_RUN:
            begin
                if (k_reg == dswmp_pkg::IDX_LAST)
                begin
                    k_next = '0;
                    if (j_reg == dswmp_pkg::IDX_LAST)
                    begin
                        j_next = '0;
                        if (i_reg == dswmp_pkg::IDX_LAST)
                        begin
                            state_next = dswmp_pkg::ENG_DRAIN;
                        end
                        else
                        begin
                            i_next = i_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        j_next = j_reg + 1'b1;
                    end
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end
            dswmp_pkg::ENG_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    state_next = dswmp_pkg::ENG_DONE;
                end
            end
            dswmp_pkg::ENG_DONE:
            begin
                // product now lives in the free slot; swap it in
                state_next = dswmp_pkg::ENG_IDLE;
                if (sq_reg)
                begin
                    b_slot_next = f_slot_reg;
                    f_slot_next = b_slot_reg;
                    b_virt_next = 1'b0;
                end
                else
                begin
                    a_slot_next = f_slot_reg;
                    f_slot_next = a_slot_reg;
                    a_virt_next = 1'b0;
                end
            end
            default:
            begin
                state_next = dswmp_pkg::ENG_IDLE;
            end
        endcase
        if (ctrl.init)
        begin
            a_slot_next = dswmp_pkg::SLOT_ACC0;
            b_slot_next = dswmp_pkg::SLOT_BASE0;
            f_slot_next = dswmp_pkg::SLOT_FREE0;
            a_virt_next = 1'b1;
            b_virt_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= dswmp_pkg::ENG_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            sq_reg     <= 1'b0;
            a_slot_reg <= dswmp_pkg::SLOT_ACC0;
            b_slot_reg <= dswmp_pkg::SLOT_BASE0;
            f_slot_reg <= dswmp_pkg::SLOT_FREE0;
            a_virt_reg <= 1'b1;
            b_virt_reg <= 1'b1;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            sq_reg     <= sq_next;
            a_slot_reg <= a_slot_next;
            b_slot_reg <= b_slot_next;
            f_slot_reg <= f_slot_next;
            a_virt_reg <= a_virt_next;
            b_virt_reg <= b_virt_next;
        end
    end

    // operand fetch; a matrix still at its start value reads as a constant
    assign x_slot = sq_reg ? b_slot_reg : a_slot_reg;

    always_comb
    begin
        if (issue)
        begin
            raddr_a = {x_slot, i_reg, k_reg};
            raddr_b = {b_slot_reg, k_reg, j_reg};
            x_cst   = sq_reg ? b_virt_reg : a_virt_reg;
            x_cbit  = sq_reg ? dswmp_pkg::comp_one(i_reg, k_reg)
                             : dswmp_pkg::ident_one(i_reg, k_reg);
            y_cst   = b_virt_reg;
            y_cbit  = dswmp_pkg::comp_one(k_reg, j_reg);
        end
        else
        begin
            // idle: port A points at acc[0][0] for the final read
            raddr_a = {a_slot_reg, {(2 * IW){1'b0}}};
            raddr_b = {b_slot_reg, {(2 * IW){1'b0}}};
            x_cst   = a_virt_reg;
            x_cbit  = 1'b1;
            y_cst   = b_virt_reg;
            y_cbit  = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        x_cst_reg  <= x_cst;
        x_cbit_reg <= x_cbit;
        y_cst_reg  <= y_cst;
        y_cbit_reg <= y_cbit;
    end

    assign x_data = x_cst_reg ? DW'(x_cbit_reg) : rdata_a;
    assign y_data = y_cst_reg ? DW'(y_cbit_reg) : rdata_b;

    dswmp_ram #(
        .WIDTH (DW),
        .DEPTH (dswmp_pkg::RAM_DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (tag_out.waddr),
        .wdata   (acc_sum),
        .raddr_a (raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (raddr_b),
        .rdata_b (rdata_b)
    );

    dswmp_modmul u_modmul (
        .clk (clk),
        .a   (x_data),
        .b   (y_data),
        .red (red)
    );

    // tags travel alongside the operands through read and multiply stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < dswmp_pkg::TAG_DEPTH; s++)
            begin
                tag_reg[s] <= '0;
            end
        end
        else
        begin
            tag_reg[0] <= '{valid: issue,
                            first: (k_reg == '0),
                            last:  (k_reg == dswmp_pkg::IDX_LAST),
                            waddr: {f_slot_reg, i_reg, j_reg}};
            for (int s = 1; s < dswmp_pkg::TAG_DEPTH; s++)
            begin
                tag_reg[s] <= tag_reg[s-1];
            end
        end
    end

    assign tag_out = tag_reg[dswmp_pkg::TAG_DEPTH-1];

    always_comb
    begin
        pipe_busy = 1'b0;
        for (int s = 0; s < dswmp_pkg::TAG_DEPTH; s++)
        begin
            pipe_busy = pipe_busy | tag_reg[s].valid;
        end
    end

    // running sum of one output entry, kept below p
    assign sum_wide = {1'b0, acc_reg} + {1'b0, red};
    assign sum_mod  = (sum_wide >= {1'b0, dswmp_pkg::MODP}) ?
                      (sum_wide - {1'b0, dswmp_pkg::MODP}) : sum_wide;
    assign acc_sum  = tag_out.first ? red : sum_mod[DW-1:0];
    assign we       = tag_out.valid & tag_out.last;

    always_ff @(posedge clk)
    begin
        if (tag_out.valid)
        begin
            acc_reg <= acc_sum;
        end
    end

    assign stat.done      = (state_reg == dswmp_pkg::ENG_DONE);
    assign stat.peek_data = x_data;

endmodule

### rtl/core/dswmp_seq.sv
// Microcoded sequencer: program counter, control ROM, exponent register,
// input handshake and output register. Depends on dswmp_pkg.
module dswmp_seq (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         target_valid,
    output logic                         target_ready,
    input  logic [dswmp_pkg::EXP_W-1:0]  target_sum,
    output logic                         ways_valid,
    input  logic                         ways_ready,
    output logic [dswmp_pkg::DATA_W-1:0] ways_mod_p,
    output dswmp_pkg::eng_ctrl_t         ctrl,
    input  dswmp_pkg::eng_stat_t         stat
);

    logic [dswmp_pkg::PC_W-1:0]   pc_reg, pc_next;
    logic [dswmp_pkg::EXP_W-1:0]  n_reg, n_next;
    logic                         out_valid_reg, out_valid_next;
    logic [dswmp_pkg::DATA_W-1:0] out_data_reg, out_data_next;
    dswmp_pkg::ucode_t            uc;
    logic                         take;
    logic                         in_fire;
    logic                         out_busy;

    assign uc       = dswmp_pkg::ucode_rom(pc_reg);
    assign in_fire  = target_valid & uc.load;
    assign out_busy = out_valid_reg & ~ways_ready;

    always_comb
    begin
        case (uc.cond)
            dswmp_pkg::COND_NEVER:    take = 1'b0;
            dswmp_pkg::COND_ALWAYS:   take = 1'b1;
            dswmp_pkg::COND_NO_INPUT: take = ~target_valid;
            dswmp_pkg::COND_N_ZERO:   take = (n_reg == '0);
            dswmp_pkg::COND_N_EVEN:   take = ~n_reg[0];
            dswmp_pkg::COND_MAT_BUSY: take = ~stat.done;
            dswmp_pkg::COND_OUT_BUSY: take = out_busy;
            default:                  take = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next        = take ? uc.target : pc_reg + 1'b1;
        n_next         = n_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (in_fire)
        begin
            n_next = target_sum;
        end
        else if (uc.mat_sq && stat.done)
        begin
            n_next = n_reg >> 1;
        end
        if (ways_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (uc.emit && !out_busy)
        begin
            out_valid_next = 1'b1;
            out_data_next  = stat.peek_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= dswmp_pkg::PC_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        out_data_reg <= out_data_next;
    end

    assign target_ready = uc.load;
    assign ways_valid   = out_valid_reg;
    assign ways_mod_p   = out_data_reg;
    assign ctrl.init    = in_fire;
    assign ctrl.req     = uc.mat_req;
    assign ctrl.sq      = uc.mat_sq;

endmodule

### rtl/core/dice_sum_ways_matrix_power_core.sv
// Top level of the dice-sum core: counts ordered die-throw sequences by
// companion-matrix powering mod 1e9+7. Depends on dswmp_pkg, dswmp_seq, dswmp_engine.
//
//  channel  | signals                                  | item
//  ---------+------------------------------------------+-------------------------
//  target   | target_valid, target_ready, target_sum   | exponent n, 63 bits
//  ways     | ways_valid, ways_ready, ways_mod_p       | count mod p, 30 bits
//
// One item at a time. A matrix product is ORDER^3 = 216 multiply-accumulates, one per
// cycle, plus start, pipeline drain and handoff steps. An item runs L + w products,
// L = bit length of n, w = its ones count: a square for every bit of n and a product
// into acc for every one bit, and n = 0 is answered without any product.
// Reset needs no clearing pass. A stalled result holds in the output register; the next
// item is accepted meanwhile and waits only at the step that writes its own result.
module dice_sum_ways_matrix_power_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         target_valid,
    output logic                         target_ready,
    input  logic [dswmp_pkg::EXP_W-1:0]  target_sum,
    output logic                         ways_valid,
    input  logic                         ways_ready,
    output logic [dswmp_pkg::DATA_W-1:0] ways_mod_p
);

    // Sequencer steps through the control ROM:
    //   idle -> test n==0 -> test bit -> acc*base -> base*base -> loop,
    //   and once n is exhausted reads acc[0][0] and emits it.
    // The engine keeps acc, base and a scratch matrix in three RAM slots and
    // swaps slot pointers after each product, so no copy pass is needed.
    // Right after an item is accepted, acc and base read as the identity and
    // the companion matrix from constants, so no RAM fill is needed either.
    dswmp_pkg::eng_ctrl_t ctrl;
    dswmp_pkg::eng_stat_t stat;

    dswmp_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .target_valid (target_valid),
        .target_ready (target_ready),
        .target_sum   (target_sum),
        .ways_valid   (ways_valid),
        .ways_ready   (ways_ready),
        .ways_mod_p   (ways_mod_p),
        .ctrl         (ctrl),
        .stat         (stat)
    );

    // Engine pipeline: RAM read -> multiply -> Barrett estimate -> q*p ->
    // remainder fix -> accumulate and write back on the last k term.
    dswmp_engine u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .stat  (stat)
    );

endmodule

### rtl/core/dswmp_checker.sv
// Port-level checker for the dice-sum core, bound to the top level.
// Depends on dswmp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dswmp_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         target_valid,
    input logic                         target_ready,
    input logic                         ways_valid,
    input logic                         ways_ready,
    input logic [dswmp_pkg::DATA_W-1:0] ways_mod_p
);

    // stalled result holds
    `DSWMP_ASSERT_NEXT(a_out_hold, ways_valid && !ways_ready, ways_valid && $stable(ways_mod_p))
    // result is fully reduced
    `DSWMP_ASSERT_NOW(a_out_range, ways_valid, ways_mod_p < dswmp_pkg::MODP)
    // one item at a time: busy right after an accept
    `DSWMP_ASSERT_NEXT(a_busy_after_accept, target_valid && target_ready, !target_ready)
    // a result only appears from the emit step, never from idle
    `DSWMP_ASSERT_NOW(a_emit_not_idle, $rose(ways_valid), !$past(target_ready))

endmodule

bind dice_sum_ways_matrix_power_core dswmp_checker u_checker (.*);
